FILE: hw/rtl/bqe_pkg.sv
package bqe_pkg;

    // default configuration
    localparam int BQE_BANDS           = 5;
    localparam int BQE_FILTER_CHANNELS = 2;

    // coefficients per band
    localparam int NCOEF = 5;

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int DELAY_W  = 48;
    localparam int PROD_W   = 52;
    localparam int ACC_W    = 56;

    localparam logic signed [ACC_W-1:0] SAT_HI = 56'sh00_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = 56'shFF_8000_0000_0000;

    typedef enum logic [2:0] {
        SEL_B0 = 3'd0,
        SEL_B1 = 3'd1,
        SEL_B2 = 3'd2,
        SEL_A1 = 3'd3,
        SEL_A2 = 3'd4
    } t_coef_sel;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_GO,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                       req_type;
        logic [2:0]                 channel;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       frame_last;
        logic [3:0]                 band_index;
        logic [2:0]                 coef_select;
        logic signed [COEF_W-1:0]   coef_value;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clamped;
        logic                       last_out;
    } t_out_word;

    // product order within a band: b0, b1, a1, b2, a2
    function automatic t_coef_sel next_sel(input t_coef_sel s);
        t_coef_sel r;
        unique case (s)
            SEL_B0:  r = SEL_B1;
            SEL_B1:  r = SEL_A1;
            SEL_A1:  r = SEL_B2;
            SEL_B2:  r = SEL_A2;
            SEL_A2:  r = SEL_B0;
            default: r = SEL_B0;
        endcase
        return r;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [DELAY_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DELAY_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DELAY_W-1:0];
        end else begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/biquad_cascade_equalizer_unit.sv
// Cascade of BANDS transposed direct form II biquads on signed 16-bit PCM, with
// separate delay state for up to two channels and one shared coefficient set.
// A coefficient write (req_type 1) loads one Q3.28 coefficient and clears that
// band's delays on all channels; it gives no result word.
// A sample on a filtered channel with the enable bit set runs through every band and
// comes out clamped to 16 bits (with the clamped flag) or truncated toward zero.
// Other samples pass through unchanged. Each band reads its two delays and five
// coefficients from single-port memories and runs five products through one
// shared 32x33 multiplier, two passes per product. The input is stalled from
// the accept of a sample until its result is in the output register, for
// filtered and pass-through samples alike, so no new sample is taken while
// one is in progress. Results leave through an output register, so the next
// word is taken while a result waits downstream.
module biquad_cascade_equalizer_unit import bqe_pkg::*; #(
    parameter int BANDS           = BQE_BANDS,
    parameter int FILTER_CHANNELS = BQE_FILTER_CHANNELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    // output channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    // configuration
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    localparam int BW            = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CD            = BANDS * NCOEF;
    localparam int CAW           = $clog2(CD);
    localparam int DelaysPerBand = FILTER_CHANNELS * 2;
    localparam int DD            = BANDS * DelaysPerBand;
    localparam int DAW           = $clog2(DD);

    // control
    t_state    r_state, n_state;
    logic      r_en;
    logic [BW-1:0] r_band;
    t_coef_sel r_sel;
    logic      r_ch;
    logic      r_last;

    // datapath
    logic signed [DELAY_W-1:0]  r_x, r_y, r_z1, r_z2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_clip;

    logic      r_out_valid;
    t_out_word r_out_word;

    // memories
    logic [COEF_W-1:0]  mem_c [CD];
    logic [CD-1:0]      r_cval;
    logic [COEF_W-1:0]  r_crd;
    logic [DELAY_W-1:0] mem_d [DD];
    logic [DD-1:0]      r_dval;
    logic [DELAY_W-1:0] r_drd;

    // strobes
    logic      w_accept;
    logic      w_filter;
    logic      w_coef_ok;
    logic      w_out_free;
    logic      w_last_band;
    logic      w_mul_done;
    logic      w_mul_start;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DELAY_W-1:0] w_mul_val;
    t_coef_sel w_nsel, w_rsel;
    logic      w_crd_en, w_drd_en, w_dwr_en;
    logic      w_dk;
    logic [CAW-1:0] w_caddr, w_cwaddr;
    logic [DAW-1:0] w_daddr;
    logic signed [ACC_W-1:0]   w_pe;
    logic signed [DELAY_W-1:0] w_dwdata;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_filter    = r_en && ({1'b0, i_in_word.channel} < 4'(FILTER_CHANNELS));
    // writes to a band past the cascade or an unknown select are dropped
    assign w_coef_ok   = ({1'b0, i_in_word.band_index} < 5'(BANDS))
                      && (i_in_word.coef_select < 3'(NCOEF));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_band = (r_band == BW'(BANDS - 1));
    assign w_nsel      = next_sel(r_sel);
    assign w_pe        = {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_word.req_type == REQ_COEF) begin
                        n_state = S_IDLE;
                    end else if (w_filter) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RD: begin
                n_state = S_GO;
            end
            S_GO: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mul_done) begin
                    if (r_sel == SEL_A2) begin
                        n_state = w_last_band ? S_OUT : S_RD;
                    end else begin
                        n_state = S_GO;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb begin
        w_mul_start = 1'b0;
        w_crd_en    = 1'b0;
        w_drd_en    = 1'b0;
        w_dwr_en    = 1'b0;
        w_dk        = 1'b0;
        w_rsel      = w_nsel;
        w_dwdata    = sat48(r_acc - w_pe);
        unique case (r_state)
            S_RD: begin
                // band start: first coefficient and z1
                w_crd_en = 1'b1;
                w_drd_en = 1'b1;
                w_rsel   = r_sel;
            end
            S_GO: begin
                w_mul_start = 1'b1;
            end
            S_WAIT: begin
                if (w_mul_done) begin
                    w_crd_en = (r_sel != SEL_A2);
                    unique case (r_sel)
                        SEL_B0: begin
                            // fetch z2 alongside b1
                            w_drd_en = 1'b1;
                            w_dk     = 1'b1;
                        end
                        SEL_A1: begin
                            w_dwr_en = 1'b1;
                        end
                        SEL_A2: begin
                            w_dwr_en = 1'b1;
                            w_dk     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign w_caddr   = CAW'(r_band * NCOEF + w_rsel);
    assign w_cwaddr  = CAW'(i_in_word.band_index * NCOEF + i_in_word.coef_select);
    assign w_daddr   = DAW'((r_band * FILTER_CHANNELS + r_ch) * 2 + w_dk);
    assign w_mul_val = ((r_sel == SEL_B0) || (r_sel == SEL_B1) || (r_sel == SEL_B2))
                     ? r_x : r_y;

    bqe_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_coef  (r_crd),
        .i_val   (w_mul_val),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // coefficient memory, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_word.req_type == REQ_COEF) && w_coef_ok) begin
            mem_c[w_cwaddr] <= i_in_word.coef_value;
        end
        if (w_crd_en) begin
            r_crd <= r_cval[w_caddr] ? mem_c[w_caddr] : '0;
        end
    end

    // delay memory; the schedule never reads an entry in the cycle it is written
    always_ff @(posedge i_clk) begin
        if (w_dwr_en) begin
            mem_d[w_daddr] <= w_dwdata;
        end
        if (w_drd_en) begin
            r_drd <= r_dval[w_daddr] ? mem_d[w_daddr] : '0;
        end
    end

    // valid bits: a coefficient write drops all delays of its band
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
            r_dval <= '0;
        end else begin
            if (w_accept && (i_in_word.req_type == REQ_COEF) && w_coef_ok) begin
                r_cval[w_cwaddr] <= 1'b1;
                for (int e = 0; e < DD; e++) begin
                    if (4'(e / DelaysPerBand) == i_in_word.band_index) begin
                        r_dval[e] <= 1'b0;
                    end
                end
            end
            if (w_dwr_en) begin
                r_dval[w_daddr] <= 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_en        <= 1'b0;
            r_band      <= '0;
            r_sel       <= SEL_B0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_band <= '0;
                r_sel  <= SEL_B0;
            end else if ((r_state == S_WAIT) && w_mul_done) begin
                r_sel <= w_nsel;
                if ((r_sel == SEL_A2) && !w_last_band) begin
                    r_band <= r_band + 1'b1;
                end
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_in_word.channel[0];
            r_last <= i_in_word.frame_last;
            r_x    <= {{16{i_in_word.sample_in[15]}}, i_in_word.sample_in, 16'b0};
            r_res  <= i_in_word.sample_in;
            r_clip <= 1'b0;
        end
        if (r_state == S_GO) begin
            if (r_sel == SEL_B0) begin
                r_z1 <= r_drd;
            end
            if (r_sel == SEL_B1) begin
                r_z2 <= r_drd;
            end
        end
        if ((r_state == S_WAIT) && w_mul_done) begin
            unique case (r_sel)
                SEL_B0: begin
                    r_y <= sat48(w_pe + {{(ACC_W-DELAY_W){r_z1[DELAY_W-1]}}, r_z1});
                end
                SEL_B1: begin
                    r_acc <= w_pe + {{(ACC_W-DELAY_W){r_z2[DELAY_W-1]}}, r_z2};
                end
                SEL_B2: begin
                    r_acc <= w_pe;
                end
                SEL_A1: begin
                end
                SEL_A2: begin
                    // band output feeds the next band
                    r_x <= r_y;
                    if (w_last_band) begin
                        if (r_y > 48'sh0000_7FFF_0000) begin
                            r_res  <= 16'sh7FFF;
                            r_clip <= 1'b1;
                        end else if (r_y < 48'shFFFF_8000_0000) begin
                            r_res  <= 16'sh8000;
                            r_clip <= 1'b1;
                        end else begin
                            // bias negatives so the shift rounds toward zero
                            r_res  <= 16'((r_y + (r_y[DELAY_W-1] ? 48'sd65535 : 48'sd0))
                                          >>> 16);
                            r_clip <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_word.sample_out <= r_res;
            r_out_word.clamped    <= r_clip;
            r_out_word.last_out   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: hw/rtl/bqe_qmul.sv
module bqe_qmul import bqe_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [COEF_W-1:0]   i_coef,
    input  logic signed [DELAY_W-1:0]  i_val,
    output logic                       o_done,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic [2:0]               r_stg;
    logic                     r_done;
    logic signed [COEF_W-1:0] r_c;
    logic signed [31:0]       r_hi;
    logic [15:0]              r_lo;
    logic signed [63:0]       r_m;
    logic signed [63:0]       r_hp;
    logic signed [PROD_W-1:0] r_p;

    logic signed [32:0] w_b;
    logic signed [64:0] w_full;
    logic signed [63:0] w_acc;

    // high half first, low half second, through one 32x33 multiplier
    assign w_b    = r_stg[0] ? {r_hi[31], r_hi} : {17'b0, r_lo};
    assign w_full = r_c * w_b;
    assign w_acc  = r_hp + {{16{r_m[63]}}, r_m[63:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end else begin
            r_stg  <= {r_stg[1:0], i_start};
            r_done <= r_stg[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_c  <= i_coef;
            r_hi <= i_val[47:16];
            r_lo <= i_val[15:0];
        end
        if (r_stg[0] || r_stg[1]) begin
            r_m <= w_full[63:0];
        end
        if (r_stg[1]) begin
            r_hp <= r_m;
        end
        if (r_stg[2]) begin
            r_p <= w_acc[63:12];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule
